// ----- rtl/hwpd_pkg.sv -----
// ----------------------------------------------------------------------------
// hwpd_pkg: shared types and constants for the haptic wall PD controller
// Field widths, fixed-point formats, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package hwpd_pkg;

   // fixed-point formats
   localparam int ANGLE_W   = 12;               // encoder angle and bound registers
   localparam int FRAC_BITS = 8;                // fraction bits of force and current
   localparam int GAIN_FRAC = 16;               // fraction bits of the Q8.16 gains
   localparam int GAIN_W    = 24;
   localparam int CSR_W     = 24;               // widest register
   localparam int CSR_AW    = 3;
   localparam int FORCE_W   = 25;               // measured force input
   localparam int OUT_W     = 21;               // both result fields

   // derived datapath widths
   localparam int FULL_W = ANGLE_W + FRAC_BITS;          // full wall force, fixed point
   localparam int PROD_W = FULL_W + ANGLE_W;             // full * distance
   localparam int DIVD_W = PROD_W + 2;                   // 2*full*distance + span
   localparam int DVSR_W = ANGLE_W + 1;                  // 2*span
   localparam int REM_W  = DVSR_W + 1;
   localparam int ERR_W  = FORCE_W + FRAC_BITS + 1;      // error
   localparam int DIFF_W = ERR_W + 1;                    // error change
   localparam int ACC_W  = DIFF_W + GAIN_W + 1;          // sum of both products
   localparam int CUR_W  = ACC_W - GAIN_FRAC;            // current before limiting
   localparam int CNT_W  = 6;

   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (GAIN_FRAC - 1);

   // register indexes
   localparam logic [CSR_AW-1:0] REG_WALL_LOW       = 3'd0;
   localparam logic [CSR_AW-1:0] REG_FREE_LOW       = 3'd1;
   localparam logic [CSR_AW-1:0] REG_FREE_HIGH      = 3'd2;
   localparam logic [CSR_AW-1:0] REG_WALL_HIGH      = 3'd3;
   localparam logic [CSR_AW-1:0] REG_WALL_FORCE_MAX = 3'd4;
   localparam logic [CSR_AW-1:0] REG_PROP_GAIN      = 3'd5;
   localparam logic [CSR_AW-1:0] REG_DERIV_GAIN     = 3'd6;
   localparam logic [CSR_AW-1:0] REG_CURRENT_LIMIT  = 3'd7;

   // register reset values
   localparam logic [ANGLE_W-1:0] RST_WALL_LOW       = 12'd2050;
   localparam logic [ANGLE_W-1:0] RST_FREE_LOW       = 12'd2450;
   localparam logic [ANGLE_W-1:0] RST_FREE_HIGH      = 12'd3050;
   localparam logic [ANGLE_W-1:0] RST_WALL_HIGH      = 12'd3450;
   localparam logic [ANGLE_W-1:0] RST_WALL_FORCE_MAX = 12'd500;
   localparam logic [GAIN_W-1:0]  RST_PROP_GAIN      = 24'd6554;
   localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN     = 24'd327680;
   localparam logic [ANGLE_W-1:0] RST_CURRENT_LIMIT  = 12'd800;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV,
      ST_SIGN,
      ST_ERR,
      ST_MULP,
      ST_DIFF,
      ST_MULD,
      ST_ROUND,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/haptic_wall_pd_controller.sv -----
// ----------------------------------------------------------------------------
// haptic_wall_pd_controller: wall force profile and PD current command
// Maps the angle to a target force, then runs a PD step with saturation.
// ----------------------------------------------------------------------------
//
//   channel | ports                                       | dir | handshake
//   --------+---------------------------------------------+-----+-------------
//   req     | req_angle, req_measured_force               | in  | valid/ready
//   rsp     | rsp_current_cmd, rsp_force_target           | out | valid/ready
//   csr     | csr_addr, csr_wdata                         | in  | csr_we only
//
// One item at a time, sequenced around a single 60-bit add/sub unit.
// Ramp angles run a 34-step divide and two 24-step shift-add multiplies;
// other angles skip the divide. req_ready returns in the same cycle that
// rsp_valid rises. A waiting result lets the
// next item in but holds it in its finish step until rsp_ready.
// Synchronous reset loads the register defaults and clears last error.
`default_nettype none

module haptic_wall_pd_controller (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire  [hwpd_pkg::ANGLE_W-1:0]          req_angle,
   input  wire  signed [hwpd_pkg::FORCE_W-1:0]   req_measured_force,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic signed [hwpd_pkg::OUT_W-1:0]     rsp_current_cmd,
   output logic signed [hwpd_pkg::OUT_W-1:0]     rsp_force_target,
   input  wire                                   csr_we,
   input  wire  [hwpd_pkg::CSR_AW-1:0]           csr_addr,
   input  wire  [hwpd_pkg::CSR_W-1:0]            csr_wdata
);

   localparam int ANGLE_W = hwpd_pkg::ANGLE_W;
   localparam int FRAC    = hwpd_pkg::FRAC_BITS;
   localparam int GAIN_W  = hwpd_pkg::GAIN_W;
   localparam int FORCE_W = hwpd_pkg::FORCE_W;
   localparam int OUT_W   = hwpd_pkg::OUT_W;
   localparam int FULL_W  = hwpd_pkg::FULL_W;
   localparam int PROD_W  = hwpd_pkg::PROD_W;
   localparam int DIVD_W  = hwpd_pkg::DIVD_W;
   localparam int DVSR_W  = hwpd_pkg::DVSR_W;
   localparam int REM_W   = hwpd_pkg::REM_W;
   localparam int ERR_W   = hwpd_pkg::ERR_W;
   localparam int DIFF_W  = hwpd_pkg::DIFF_W;
   localparam int ACC_W   = hwpd_pkg::ACC_W;
   localparam int CUR_W   = hwpd_pkg::CUR_W;
   localparam int CNT_W   = hwpd_pkg::CNT_W;

   // configuration registers
   logic [ANGLE_W-1:0] wall_low_ff, free_low_ff, free_high_ff, wall_high_ff;
   logic [ANGLE_W-1:0] wall_force_max_ff, current_limit_ff;
   logic [GAIN_W-1:0]  prop_gain_ff, deriv_gain_ff;

   // sequencer and datapath registers
   hwpd_pkg::state_type       state_ff, state_in;
   logic [ANGLE_W-1:0]        angle_ff;
   logic signed [FORCE_W-1:0] meas_ff;
   logic                      ramp_neg_ff, ramp_neg_in;
   logic [DIVD_W-1:0]         divd_ff, divd_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [DVSR_W-1:0]         dvsr_ff, dvsr_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic signed [OUT_W-1:0]   target_ff, target_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [ERR_W-1:0]   last_err_ff, last_err_in;
   logic [ACC_W-1:0]          mcand_ff, mcand_in;
   logic [GAIN_W-1:0]         mplier_ff, mplier_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]   cur_out_ff, cur_out_in;
   logic signed [OUT_W-1:0]   tgt_out_ff, tgt_out_in;

   // shared add/sub unit
   logic [ACC_W-1:0] add_a, add_b, add_res;
   logic             add_sub;

   // profile decode
   logic [FULL_W-1:0]  full;
   logic               at_low_wall, at_high_wall, in_free, on_left;
   logic [ANGLE_W-1:0] ramp_dist, span;
   logic [PROD_W-1:0]  prod;
   logic [REM_W-1:0]   div_shift;
   logic               div_ok;
   logic [OUT_W-1:0]   quot;
   logic signed [CUR_W-1:0] cur, lim;
   logic               load_out;
   logic               accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == hwpd_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_current_cmd  = cur_out_ff;
   assign rsp_force_target = tgt_out_ff;

   assign add_res = add_a + (add_sub ? ~add_b : add_b) + ACC_W'(add_sub);

   // angle profile decode, used in the setup step
   assign full         = {wall_force_max_ff, {FRAC{1'b0}}};
   assign at_low_wall  = (angle_ff <= wall_low_ff);
   assign at_high_wall = (angle_ff >= wall_high_ff);
   assign in_free      = (angle_ff >= free_low_ff) && (angle_ff <= free_high_ff);
   assign on_left      = (angle_ff < free_low_ff);
   assign ramp_dist = on_left ? (free_low_ff - angle_ff) : (angle_ff - free_high_ff);
   assign span = on_left ? (free_low_ff - wall_low_ff) : (wall_high_ff - free_high_ff);
   assign prod = full * ramp_dist;

   // restoring divide step: bring down one dividend bit, trial subtract
   assign div_shift = {rem_ff[REM_W-2:0], divd_ff[DIVD_W-1]};
   assign div_ok    = !add_res[ACC_W-1];
   assign quot      = {1'b0, divd_ff[OUT_W-2:0]};

   // rounded current and its limit
   assign cur  = $signed(acc_ff[ACC_W-1:hwpd_pkg::GAIN_FRAC]);
   assign lim  = $signed({{(CUR_W-FULL_W){1'b0}}, current_limit_ff, {FRAC{1'b0}}});
   assign load_out = (state_ff == hwpd_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         wall_low_ff       <= hwpd_pkg::RST_WALL_LOW;
         free_low_ff       <= hwpd_pkg::RST_FREE_LOW;
         free_high_ff      <= hwpd_pkg::RST_FREE_HIGH;
         wall_high_ff      <= hwpd_pkg::RST_WALL_HIGH;
         wall_force_max_ff <= hwpd_pkg::RST_WALL_FORCE_MAX;
         prop_gain_ff      <= hwpd_pkg::RST_PROP_GAIN;
         deriv_gain_ff     <= hwpd_pkg::RST_DERIV_GAIN;
         current_limit_ff  <= hwpd_pkg::RST_CURRENT_LIMIT;
      end else if (csr_we) begin
         unique case (csr_addr)
            hwpd_pkg::REG_WALL_LOW:       wall_low_ff       <= csr_wdata[ANGLE_W-1:0];
            hwpd_pkg::REG_FREE_LOW:       free_low_ff       <= csr_wdata[ANGLE_W-1:0];
            hwpd_pkg::REG_FREE_HIGH:      free_high_ff      <= csr_wdata[ANGLE_W-1:0];
            hwpd_pkg::REG_WALL_HIGH:      wall_high_ff      <= csr_wdata[ANGLE_W-1:0];
            hwpd_pkg::REG_WALL_FORCE_MAX: wall_force_max_ff <= csr_wdata[ANGLE_W-1:0];
            hwpd_pkg::REG_PROP_GAIN:      prop_gain_ff      <= csr_wdata[GAIN_W-1:0];
            hwpd_pkg::REG_DERIV_GAIN:     deriv_gain_ff     <= csr_wdata[GAIN_W-1:0];
            hwpd_pkg::REG_CURRENT_LIMIT:  current_limit_ff  <= csr_wdata[ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hwpd_pkg::ST_IDLE:
            if (accept) state_in = hwpd_pkg::ST_SETUP;
         hwpd_pkg::ST_SETUP:
            if (at_low_wall || at_high_wall || in_free || (span == '0)) begin
               state_in = hwpd_pkg::ST_ERR;
            end else begin
               state_in = hwpd_pkg::ST_DIV;
            end
         hwpd_pkg::ST_DIV:
            if (cnt_ff == '0) state_in = hwpd_pkg::ST_SIGN;
         hwpd_pkg::ST_SIGN:  state_in = hwpd_pkg::ST_ERR;
         hwpd_pkg::ST_ERR:   state_in = hwpd_pkg::ST_MULP;
         hwpd_pkg::ST_MULP:
            if (cnt_ff == '0) state_in = hwpd_pkg::ST_DIFF;
         hwpd_pkg::ST_DIFF:  state_in = hwpd_pkg::ST_MULD;
         hwpd_pkg::ST_MULD:
            if (cnt_ff == '0) state_in = hwpd_pkg::ST_ROUND;
         hwpd_pkg::ST_ROUND: state_in = hwpd_pkg::ST_FINISH;
         hwpd_pkg::ST_FINISH:
            if (load_out) state_in = hwpd_pkg::ST_IDLE;
         default: state_in = hwpd_pkg::ST_IDLE;
      endcase
   end

   // datapath controls and register next values
   always_comb begin
      add_a       = '0;
      add_b       = '0;
      add_sub     = 1'b0;
      ramp_neg_in = ramp_neg_ff;
      divd_in     = divd_ff;
      rem_in      = rem_ff;
      dvsr_in     = dvsr_ff;
      cnt_in      = cnt_ff;
      target_in   = target_ff;
      err_in      = err_ff;
      last_err_in = last_err_ff;
      mcand_in    = mcand_ff;
      mplier_in   = mplier_ff;
      acc_in      = acc_ff;
      unique case (state_ff)
         hwpd_pkg::ST_SETUP: begin
            // walls first, then free zone, then the two ramps
            ramp_neg_in = on_left;
            divd_in     = {prod, 1'b0} + DIVD_W'(span);
            dvsr_in     = {span, 1'b0};
            rem_in      = '0;
            cnt_in      = CNT_W'(DIVD_W - 1);
            if (at_low_wall) begin
               target_in = -$signed({1'b0, full});
            end else if (at_high_wall) begin
               target_in = $signed({1'b0, full});
            end else begin
               target_in = '0;
            end
         end
         hwpd_pkg::ST_DIV: begin
            add_a   = ACC_W'(div_shift);
            add_b   = ACC_W'(dvsr_ff);
            add_sub = 1'b1;
            rem_in  = div_ok ? add_res[REM_W-1:0] : div_shift;
            divd_in = {divd_ff[DIVD_W-2:0], div_ok};
            cnt_in  = cnt_ff - 1'b1;
         end
         hwpd_pkg::ST_SIGN:
            target_in = ramp_neg_ff ? -$signed(quot) : $signed(quot);
         hwpd_pkg::ST_ERR: begin
            // target minus scaled reading; always within the error width
            add_a     = {{(ACC_W-OUT_W){target_ff[OUT_W-1]}}, target_ff};
            add_b     = {{(ACC_W-FORCE_W-FRAC){meas_ff[FORCE_W-1]}}, meas_ff,
                         {FRAC{1'b0}}};
            add_sub   = 1'b1;
            err_in    = $signed(add_res[ERR_W-1:0]);
            mcand_in  = {{(ACC_W-ERR_W){add_res[ERR_W-1]}}, add_res[ERR_W-1:0]};
            mplier_in = prop_gain_ff;
            acc_in    = '0;
            cnt_in    = CNT_W'(GAIN_W - 1);
         end
         hwpd_pkg::ST_MULP, hwpd_pkg::ST_MULD: begin
            // shift-add, gain LSB first
            add_a     = acc_ff;
            add_b     = mcand_ff;
            acc_in    = mplier_ff[0] ? add_res : acc_ff;
            mcand_in  = {mcand_ff[ACC_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[GAIN_W-1:1]};
            cnt_in    = cnt_ff - 1'b1;
         end
         hwpd_pkg::ST_DIFF: begin
            // error change; both operands fit the error width, so no overflow
            add_a       = {{(ACC_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
            add_b       = {{(ACC_W-ERR_W){last_err_ff[ERR_W-1]}}, last_err_ff};
            add_sub     = 1'b1;
            mcand_in    = {{(ACC_W-DIFF_W){add_res[DIFF_W-1]}}, add_res[DIFF_W-1:0]};
            mplier_in   = deriv_gain_ff;
            last_err_in = err_ff;
            cnt_in      = CNT_W'(GAIN_W - 1);
         end
         hwpd_pkg::ST_ROUND: begin
            add_a  = acc_ff;
            add_b  = hwpd_pkg::ROUND_HALF;
            acc_in = add_res;
         end
         default: ;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      cur_out_in   = cur_out_ff;
      tgt_out_in   = tgt_out_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         tgt_out_in   = target_ff;
         if (cur > lim) begin
            cur_out_in = lim[OUT_W-1:0];
         end else if (cur < -lim) begin
            cur_out_in = -lim[OUT_W-1:0];
         end else begin
            cur_out_in = cur[OUT_W-1:0];
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hwpd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         last_err_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_err_ff  <= last_err_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         angle_ff <= req_angle;
         meas_ff  <= req_measured_force;
      end
      ramp_neg_ff <= ramp_neg_in;
      divd_ff     <= divd_in;
      rem_ff      <= rem_in;
      dvsr_ff     <= dvsr_in;
      cnt_ff      <= cnt_in;
      target_ff   <= target_in;
      err_ff      <= err_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      acc_ff      <= acc_in;
      cur_out_ff  <= cur_out_in;
      tgt_out_ff  <= tgt_out_in;
   end

`ifndef SYNTHESIS
   // a transfer always starts the setup step
   a_accept_setup: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == hwpd_pkg::ST_SETUP))
      else $error("transfer did not start setup");

   // divider remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hwpd_pkg::ST_DIV) |-> (REM_W'(dvsr_ff) > rem_ff))
      else $error("divider remainder out of range");

   // a new result appears only from the finish step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == hwpd_pkg::ST_FINISH))
      else $error("result raised outside finish step");

   // no second item is taken right after a transfer
   a_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("ready right after transfer");
`endif

endmodule

`default_nettype wire
